FILE: design/tm_pkg.sv
// shared constants for the trajectory metrics block
`timescale 1ns / 1ps
package tm_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int INV_WIDTH       = 32;
    localparam int SUM_WIDTH       = 40;
    localparam int ERR_WIDTH       = 25;
    localparam int SPEED_SHIFT     = 16;
    localparam int SPEED_SAT_BIT   = 56;
    localparam int PROD_EXT_WIDTH  = 65;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TARGET_X  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TARGET_Y  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INV_STEP  = 2'd2;

    localparam logic [INV_WIDTH-1:0] INV_STEP_RESET = 32'd65536;

    // handshake between the sequencer and the hypot unit
    typedef struct packed {
        logic start;
    } tm_hyp_req_t;

    typedef struct packed {
        logic done;
    } tm_hyp_rsp_t;

endpackage

FILE: design/trajectory_metrics_top.sv
// trajectory metrics top level: pose sequencer, path sums and serial speed multiply
`timescale 1ns / 1ps
// with N = COORD_WIDTH + 1 (25 by default), a first pose not marked last is only stored;
// a later pose runs tm_hypot on the step, a squaring phase and then a root phase;
// a last pose after another adds a hypot pass for the target error and an N-bit serial multiply,
// and its result is loaded after the multiply, later if out is full
// rst_n is asynchronous and active low; it restores the register defaults
// (targets 0, inverse step time 1.0) and clears all trajectory state
module trajectory_metrics_top #(
    parameter int COORD_WIDTH = tm_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [tm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [tm_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    // pose channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_WIDTH-1:0]       pos_x,
    input  logic signed [COORD_WIDTH-1:0]       pos_y,
    input  logic                                last,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tm_pkg::SUM_WIDTH-1:0]        total_distance,
    output logic [tm_pkg::ERR_WIDTH-1:0]        final_error,
    output logic [tm_pkg::SUM_WIDTH-1:0]        max_speed
);
    import tm_pkg::*;

    localparam int N     = COORD_WIDTH + 1;
    localparam int PW    = N + INV_WIDTH;
    localparam int CNT_W = $clog2(N);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_ERR,
        S_MUL,
        S_OUT
    } state_t;

    state_t                         state_reg;

    // configuration registers
    logic signed [COORD_WIDTH-1:0]  target_x_reg;
    logic signed [COORD_WIDTH-1:0]  target_y_reg;
    logic [INV_WIDTH-1:0]           inv_step_reg;

    // trajectory state
    logic signed [COORD_WIDTH-1:0]  prev_x_reg;
    logic signed [COORD_WIDTH-1:0]  prev_y_reg;
    logic                           have_prev_reg;
    logic [SUM_WIDTH-1:0]           sum_reg;
    logic [N-1:0]                   longest_reg;

    // current pose held while its work runs
    logic signed [COORD_WIDTH-1:0]  cur_x_reg;
    logic signed [COORD_WIDTH-1:0]  cur_y_reg;
    logic                           last_reg;

    logic [ERR_WIDTH-1:0]           err_reg;
    logic [PW-1:0]                  mul_acc_reg;
    logic [N-1:0]                   mul_b_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           out_valid_reg;

    logic                           in_fire;
    logic                           out_free;
    tm_hyp_req_t                    hyp_req;
    tm_hyp_rsp_t                    hyp_rsp;
    logic [N-1:0]                   hyp_root;
    logic [N-1:0]                   mag_x;
    logic [N-1:0]                   mag_y;
    logic signed [COORD_WIDTH-1:0]  a_x;
    logic signed [COORD_WIDTH-1:0]  a_y;
    logic signed [COORD_WIDTH-1:0]  b_x;
    logic signed [COORD_WIDTH-1:0]  b_y;
    logic signed [N-1:0]            diff_x;
    logic signed [N-1:0]            diff_y;
    logic [SUM_WIDTH:0]             sum_wide;
    logic [SUM_WIDTH-1:0]           sum_next;
    logic [N-1:0]                   longest_next;
    logic [INV_WIDTH:0]             mul_sum;
    logic [PW-1:0]                  mul_acc_next;
    logic [PROD_EXT_WIDTH-1:0]      prod_ext;
    logic [SUM_WIDTH-1:0]           speed;
    logic [63:0]                    root_ext;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // operand select: step length in idle when a pose came before, target error otherwise
    always_comb
    begin
        a_x = (state_reg == S_IDLE) ? pos_x : cur_x_reg;
        a_y = (state_reg == S_IDLE) ? pos_y : cur_y_reg;
        b_x = ((state_reg == S_IDLE) && have_prev_reg) ? prev_x_reg : target_x_reg;
        b_y = ((state_reg == S_IDLE) && have_prev_reg) ? prev_y_reg : target_y_reg;
        diff_x = {a_x[COORD_WIDTH-1], a_x} - {b_x[COORD_WIDTH-1], b_x};
        diff_y = {a_y[COORD_WIDTH-1], a_y} - {b_y[COORD_WIDTH-1], b_y};
        // the most negative difference, 1 - 2^COORD_WIDTH, negates to 2^COORD_WIDTH - 1, correct when read unsigned
        mag_x = diff_x[N-1] ? (~diff_x + 1'b1) : diff_x;
        mag_y = diff_y[N-1] ? (~diff_y + 1'b1) : diff_y;
    end

    // kick the hypot unit for a step length or for the target error
    assign hyp_req.start = (in_fire && (have_prev_reg || last))
                        || ((state_reg == S_STEP) && hyp_rsp.done && last_reg);

    tm_hypot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_hypot (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hyp_req),
        .mag_a (mag_x),
        .mag_b (mag_y),
        .rsp   (hyp_rsp),
        .root  (hyp_root)
    );

    // saturating path sum and running longest step
    always_comb
    begin
        sum_wide     = {1'b0, sum_reg} + (SUM_WIDTH + 1)'(hyp_root);
        sum_next     = sum_wide[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_wide[SUM_WIDTH-1:0];
        longest_next = (hyp_root > longest_reg) ? hyp_root : longest_reg;
        root_ext     = 64'(hyp_root);
    end

    // shift-add multiply of longest step by inverse step time, lsb first
    always_comb
    begin
        mul_sum      = {1'b0, mul_acc_reg[PW-1:N]}
                     + (mul_b_reg[0] ? {1'b0, inv_step_reg} : {(INV_WIDTH + 1){1'b0}});
        mul_acc_next = {mul_sum, mul_acc_reg[N-1:1]};
        prod_ext     = PROD_EXT_WIDTH'(mul_acc_reg);
        // anything at or above bit 56 no longer fits after the q16 shift
        speed        = (|prod_ext[PROD_EXT_WIDTH-1:SPEED_SAT_BIT]) ? {SUM_WIDTH{1'b1}}
                     : prod_ext[SPEED_SAT_BIT-1:SPEED_SHIFT];
    end

    // configuration writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg <= '0;
            target_y_reg <= '0;
            inv_step_reg <= INV_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_X: target_x_reg <= cfg_data[COORD_WIDTH-1:0];
                CFG_TARGET_Y: target_y_reg <= cfg_data[COORD_WIDTH-1:0];
                CFG_INV_STEP: inv_step_reg <= cfg_data[INV_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer with trajectory state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            sum_reg       <= '0;
            longest_reg   <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            // a new result replaces the one being taken in the same cycle
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        prev_x_reg    <= pos_x;
                        prev_y_reg    <= pos_y;
                        have_prev_reg <= 1'b1;
                        if (have_prev_reg)
                        begin
                            state_reg <= S_STEP;
                        end
                        else if (last)
                        begin
                            state_reg <= S_ERR;
                        end
                    end
                end
                S_STEP:
                begin
                    if (hyp_rsp.done)
                    begin
                        sum_reg     <= sum_next;
                        longest_reg <= longest_next;
                        state_reg   <= last_reg ? S_ERR : S_IDLE;
                    end
                end
                S_ERR:
                begin
                    if (hyp_rsp.done)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (cnt_reg == CNT_W'(N - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    // hold here until the previous result transaction is gone
                    if (out_free)
                    begin
                        prev_x_reg    <= '0;
                        prev_y_reg    <= '0;
                        have_prev_reg <= 1'b0;
                        sum_reg       <= '0;
                        longest_reg   <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_x_reg <= pos_x;
            cur_y_reg <= pos_y;
            last_reg  <= last;
        end
        if ((state_reg == S_ERR) && hyp_rsp.done)
        begin
            err_reg     <= root_ext[ERR_WIDTH-1:0];
            mul_acc_reg <= '0;
            mul_b_reg   <= longest_reg;
        end
        if (state_reg == S_MUL)
        begin
            mul_acc_reg <= mul_acc_next;
            mul_b_reg   <= {1'b0, mul_b_reg[N-1:1]};
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            total_distance <= sum_reg;
            final_error    <= err_reg;
            max_speed      <= speed;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/tm_hypot.sv
// bit-serial hypot unit: serial squaring then one root bit per cycle
`timescale 1ns / 1ps
module tm_hypot #(
    parameter int COORD_WIDTH = tm_pkg::COORD_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tm_pkg::tm_hyp_req_t      req,
    input  logic [COORD_WIDTH:0]     mag_a,
    input  logic [COORD_WIDTH:0]     mag_b,
    output tm_pkg::tm_hyp_rsp_t      rsp,
    output logic [COORD_WIDTH:0]     root
);
    import tm_pkg::*;

    localparam int N     = COORD_WIDTH + 1;
    localparam int AW    = 2 * N + 1;
    localparam int CNT_W = $clog2(N);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SQUARE,
        PH_ROOT
    } phase_t;

    phase_t             phase_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [N-1:0]       ma_reg;
    logic [N-1:0]       mb_reg;
    logic [N-1:0]       sa_reg;
    logic [N-1:0]       sb_reg;
    logic [AW-1:0]      acc_reg;
    logic [2*N-1:0]     rad_reg;
    logic [N:0]         rem_reg;
    logic [N-1:0]       q_reg;

    logic [N+1:0]       sq_sum;
    logic [AW-1:0]      acc_next;
    logic [N+2:0]       rp;
    logic [N+3:0]       diff;
    logic               last_cnt;

    // partial product: add both selected magnitudes, then shift right
    always_comb
    begin
        sq_sum = {1'b0, acc_reg[AW-1:N]}
               + {2'b00, (sa_reg[0] ? ma_reg : {N{1'b0}})}
               + {2'b00, (sb_reg[0] ? mb_reg : {N{1'b0}})};
        acc_next = {sq_sum, acc_reg[N-1:1]};
    end

    // restoring root step on the next two radicand bits
    always_comb
    begin
        rp   = {rem_reg, rad_reg[2*N-1:2*N-2]};
        diff = {1'b0, rp} - {2'b00, q_reg, 2'b01};
    end

    assign last_cnt = (cnt_reg == CNT_W'(N - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                    begin
                        phase_reg <= PH_SQUARE;
                        cnt_reg   <= '0;
                    end
                end
                PH_SQUARE:
                begin
                    if (last_cnt)
                    begin
                        phase_reg <= PH_ROOT;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                PH_ROOT:
                begin
                    if (last_cnt)
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    ma_reg  <= mag_a;
                    mb_reg  <= mag_b;
                    sa_reg  <= mag_a;
                    sb_reg  <= mag_b;
                    acc_reg <= '0;
                end
            end
            PH_SQUARE:
            begin
                acc_reg <= acc_next;
                sa_reg  <= {1'b0, sa_reg[N-1:1]};
                sb_reg  <= {1'b0, sb_reg[N-1:1]};
                if (last_cnt)
                begin
                    rad_reg <= acc_next[2*N-1:0];
                    rem_reg <= '0;
                    q_reg   <= '0;
                end
            end
            PH_ROOT:
            begin
                rad_reg <= {rad_reg[2*N-3:0], 2'b00};
                if (!diff[N+3])
                begin
                    rem_reg <= diff[N:0];
                    q_reg   <= {q_reg[N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rp[N:0];
                    q_reg   <= {q_reg[N-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign root     = q_reg;

endmodule
